// File: hdl/storage_eviction_planner_unit_assert.svh
// Assertion macros shared by the eviction planner modules.
// Needs a clock and an active-low reset signal name at each use.
`ifndef STORAGE_EVICTION_PLANNER_UNIT_ASSERT_SVH
`define STORAGE_EVICTION_PLANNER_UNIT_ASSERT_SVH
// Implication checked every clock edge outside reset.
`define SEP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SEP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hdl/sep_pkg.sv
// Package of the storage eviction planner: types and fixed encodings.
// No dependencies.
`timescale 1ns / 1ps
package sep_pkg;
    localparam int NUM_W   = 32;
    localparam int BYTES_W = 48;

    // Configuration register indexes.
    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_USED     = 1'b1;

    // Result kinds.
    localparam logic KIND_DELETE  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PREP,
        ST_WALK,
        ST_SUMM
    } t_state;

    // Command passed from the front part to the back part.
    typedef struct packed {
        logic               kind;
        logic [NUM_W-1:0]   number;
        logic               req;
        logic               prot;
        logic               reach;
    } t_cmd;
endpackage

// File: hdl/sep_fifo.sv
// Short queue between the planner front and the result back end.
// Uses sep_pkg for the command type.
`timescale 1ns / 1ps
module sep_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sep_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sep_pkg::t_cmd o_data
);
    import sep_pkg::*;
    t_cmd       r_mem [4];
    logic [2:0] r_wp, r_rp;

    assign o_full  = (r_wp[1:0] == r_rp[1:0]) && (r_wp[2] != r_rp[2]);
    assign o_empty = (r_wp == r_rp);
    assign o_data  = r_mem[r_rp[1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[1:0]] <= i_data;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 3'd0;
            r_rp <= 3'd0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 3'd1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 3'd1;
            end
        end
    end
endmodule

// File: hdl/sep_front.sv
// Front part: sorted insertion of session records and the eviction walk.
// Uses sep_pkg; pushes commands into the queue.
`timescale 1ns / 1ps
`include "storage_eviction_planner_unit_assert.svh"
module sep_front #(
    parameter int MAX_SESSIONS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [sep_pkg::BYTES_W-1:0] i_capacity,
    input  logic [sep_pkg::BYTES_W-1:0] i_used,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [sep_pkg::NUM_W-1:0]   i_number,
    input  logic [sep_pkg::BYTES_W-1:0] i_bytes,
    input  logic                        i_elig,
    input  logic                        i_last,
    output logic                        o_push,
    output sep_pkg::t_cmd               o_cmd,
    input  logic                        i_full,
    output logic                        o_idle
);
    import sep_pkg::*;
    localparam int CW = $clog2(MAX_SESSIONS + 1);
    localparam int IW = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;

    // Slots are a row of cells: each one shifts from its lower neighbor.
    logic [NUM_W-1:0]   r_num [MAX_SESSIONS];
    logic [BYTES_W-1:0] r_sz  [MAX_SESSIONS];
    logic               r_el  [MAX_SESSIONS];
    logic [CW-1:0]      r_cnt, r_idx;
    logic [BYTES_W-1:0] r_rem;
    logic [BYTES_W+3:0] r_tgt7;
    logic               r_req;
    logic               r_prot;
    t_state             r_st, n_st;

    logic [BYTES_W+2:0] w_rem5, w_cap4;
    logic [BYTES_W+3:0] w_rem10, w_cap7;
    logic               w_acc, w_store, w_more;

    assign w_acc   = i_valid && !o_stall;
    assign w_store = w_acc && (r_cnt < CW'(MAX_SESSIONS));
    assign o_stall = (r_st != ST_LOAD);
    assign o_idle  = (r_st == ST_LOAD);

    // Since usage is an integer, used >= ceil(4c/5) holds exactly when 5*used >= 4c,
    // and rem >= ceil(7c/10) exactly when 10*rem >= 7c, so no division is needed.
    assign w_rem5  = {1'b0, r_rem, 2'b00} + {3'b000, r_rem};
    assign w_cap4  = {1'b0, i_capacity, 2'b00};
    assign w_rem10 = {1'b0, r_rem, 3'b000} + {3'b000, r_rem, 1'b0};
    assign w_cap7  = {1'b0, i_capacity, 3'b000} - {4'b0000, i_capacity};

    assign w_more = (r_idx < r_cnt) && (w_rem10 >= r_tgt7);

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_LOAD: if (w_acc && i_last) n_st = ST_PREP;
            ST_PREP: n_st = ST_WALK;
            ST_WALK: if (!r_req || !w_more) n_st = ST_SUMM;
            ST_SUMM: if (!i_full) n_st = ST_LOAD;
            default: n_st = ST_LOAD;
        endcase
    end

    always_comb begin
        o_push       = 1'b0;
        o_cmd        = '0;
        case (r_st)
            ST_WALK: begin
                if (r_req && w_more && r_el[r_idx[IW-1:0]] && !i_full) begin
                    o_push       = 1'b1;
                    o_cmd.kind   = KIND_DELETE;
                    o_cmd.number = r_num[r_idx[IW-1:0]];
                end
            end
            ST_SUMM: begin
                o_push      = !i_full;
                o_cmd.kind  = KIND_SUMMARY;
                o_cmd.req   = r_req;
                o_cmd.prot  = r_req && r_prot;
                o_cmd.reach = r_req && (w_rem10 < r_tgt7);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_SESSIONS; k++) begin
            if (w_store && (CW'(k) <= r_cnt)) begin
                if ((CW'(k) == r_cnt || r_num[k] > i_number) &&
                    (k == 0 || !(r_num[k-1 < 0 ? 0 : k-1] > i_number))) begin
                    r_num[k] <= i_number;
                    r_sz[k]  <= i_bytes;
                    r_el[k]  <= i_elig;
                end else if (k > 0 && r_num[k-1 < 0 ? 0 : k-1] > i_number) begin
                    r_num[k] <= r_num[k-1 < 0 ? 0 : k-1];
                    r_sz[k]  <= r_sz[k-1 < 0 ? 0 : k-1];
                    r_el[k]  <= r_el[k-1 < 0 ? 0 : k-1];
                end
            end
        end
        if (r_st == ST_PREP) begin
            r_tgt7 <= w_cap7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_LOAD;
            r_cnt  <= '0;
            r_idx  <= '0;
            r_rem  <= '0;
            r_req  <= 1'b0;
            r_prot <= 1'b0;
        end else begin
            r_st <= n_st;
            case (r_st)
                ST_LOAD: begin
                    if (w_store) r_cnt <= r_cnt + CW'(1);
                    r_rem  <= i_used;
                    r_idx  <= '0;
                    r_prot <= 1'b0;
                end
                ST_PREP: begin
                    r_req <= (i_capacity != '0) && (w_rem5 >= w_cap4);
                end
                ST_WALK: begin
                    if (r_req && w_more) begin
                        if (!r_el[r_idx[IW-1:0]]) begin
                            if (r_sz[r_idx[IW-1:0]] != '0) r_prot <= 1'b1;
                            r_idx <= r_idx + CW'(1);
                        end else if (!i_full) begin
                            r_rem <= (r_sz[r_idx[IW-1:0]] >= r_rem) ? '0
                                   : r_rem - r_sz[r_idx[IW-1:0]];
                            r_idx <= r_idx + CW'(1);
                        end
                    end
                end
                ST_SUMM: if (!i_full) r_cnt <= '0;
                default: ;
            endcase
        end
    end

    `SEP_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_SESSIONS))
    `SEP_ASSERT_IMP(a_push_room, i_clk, i_rst_n, o_push, !i_full)
    `SEP_ASSERT_NXT(a_summ_done, i_clk, i_rst_n, (r_st == ST_SUMM) && !i_full, r_cnt == '0)
endmodule

// File: hdl/sep_back.sv
// Back part: turns queued commands into result beats through an output register.
// Uses sep_pkg for the command type.
`timescale 1ns / 1ps
module sep_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  sep_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_kind,
    output logic [sep_pkg::NUM_W-1:0] o_delete_number,
    output logic                      o_cleanup_required,
    output logic                      o_protected_remains,
    output logic                      o_target_reached,
    output logic                      o_last_result,
    output logic                      o_idle
);
    import sep_pkg::*;
    logic r_valid;
    t_cmd r_cmd;

    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_idle  = i_empty && !r_valid;
    assign o_kind              = r_cmd.kind;
    assign o_delete_number     = r_cmd.number;
    assign o_cleanup_required  = r_cmd.req;
    assign o_protected_remains = r_cmd.prot;
    assign o_target_reached    = r_cmd.reach;
    assign o_last_result       = (r_cmd.kind == KIND_SUMMARY);

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_cmd;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end
endmodule

// File: hdl/storage_eviction_planner_unit.sv
// Storage eviction planner: one record per cycle while loading, walk after the last.
// After the last record a prepare state decides whether cleanup is required; the walk then
// visits slots in ascending session number, waiting on a full queue, until the target or the end.
// Delete beats and then the summary pass through the queue; input is stalled from the last record to summary.
// Synchronous active-low reset clears control state; session slots need no clearing.
// Uses sep_pkg, sep_front, sep_fifo and sep_back.
`timescale 1ns / 1ps
module storage_eviction_planner_unit #(
    parameter int MAX_SESSIONS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_session_number,
    input  logic [47:0] i_session_bytes,
    input  logic        i_inactive,
    input  logic        i_points_confirmed,
    input  logic        i_log_confirmed,
    input  logic        i_last_session,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [31:0] o_delete_number,
    output logic        o_cleanup_required,
    output logic        o_protected_remains,
    output logic        o_target_reached,
    output logic        o_last_result
);
    import sep_pkg::*;
    // The configuration registers are always writable.
    logic [47:0] r_capacity, r_used;
    logic        w_push, w_full, w_pop, w_empty, w_fidle, w_bidle;
    t_cmd        w_in, w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
            r_used     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAPACITY: r_capacity <= i_cfg_data;
                CFG_USED:     r_used     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sep_front #(.MAX_SESSIONS(MAX_SESSIONS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_capacity(r_capacity), .i_used(r_used),
        .i_valid(i_valid), .o_stall(o_stall), .i_number(i_session_number),
        .i_bytes(i_session_bytes),
        .i_elig(i_inactive & i_points_confirmed & i_log_confirmed),
        .i_last(i_last_session), .o_push(w_push), .o_cmd(w_in), .i_full(w_full),
        .o_idle(w_fidle)
    );

    sep_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_in),
        .o_full(w_full), .i_pop(w_pop), .o_empty(w_empty), .o_data(w_out)
    );

    sep_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty), .i_cmd(w_out),
        .o_pop(w_pop), .o_valid(o_valid), .i_stall(i_stall), .o_kind(o_kind),
        .o_delete_number(o_delete_number), .o_cleanup_required(o_cleanup_required),
        .o_protected_remains(o_protected_remains), .o_target_reached(o_target_reached),
        .o_last_result(o_last_result), .o_idle(w_bidle)
    );

    `SEP_ASSERT_IMP(a_out_kind, i_clk, i_rst_n, o_valid && !o_kind, !o_last_result)
    `SEP_ASSERT_IMP(a_idle_out, i_clk, i_rst_n, w_fidle && w_bidle, !o_valid)
    `SEP_ASSERT_NXT(a_held, i_clk, i_rst_n, o_valid && i_stall, o_valid)
endmodule
